>>> rtl/lcdx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdx_pkg
// Shared types and constants of the character LCD nibble expander sequencer.
// ----------------------------------------------------------------------------
package lcdx_pkg;

	// default characters per display row
	localparam int ROW_CHARS_DEF = 16;

	// number of jobs held between front and back
	localparam int QUEUE_DEPTH = 2;

	// operation modes
	typedef enum logic [2:0] {
		MODE_CMD      = 3'd0,
		MODE_DATA     = 3'd1,
		MODE_CHAR     = 3'd2,
		MODE_STR_HOME = 3'd3,
		MODE_GLYPH    = 3'd4,
		MODE_STR_POS  = 3'd5
	} mode_t;

	// lcd command bytes
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [7:0] CMD_LINE2     = 8'hC0;
	localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
	localparam logic [7:0] ROW2_BASE     = 8'h40;

	// one lcd operation, already classified
	typedef struct packed {
		logic       err;
		logic       cmd_en;
		logic [7:0] cmd;
		logic       dat_en;
		logic [7:0] dat;
	} job_t;

endpackage

>>> rtl/lcdx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdx_front
// Accepts lcd operations, checks them, tracks string state, queues a job.
// ----------------------------------------------------------------------------
module lcdx_front #(
	parameter int ROW_CHARS = lcdx_pkg::ROW_CHARS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [2:0]      mode,
	input  logic [7:0]      value,
	input  logic [7:0]      row,
	input  logic [7:0]      position,
	input  logic            first,
	input  logic [7:0]      glyph_address,
	input  logic [2:0]      glyph_row,
	input  logic            q_full,
	output logic            q_push,
	output lcdx_pkg::job_t  job
);

	localparam logic [7:0] POS_MAX      = 8'(ROW_CHARS);
	localparam logic [6:0] CNT_ROW      = 7'(ROW_CHARS);
	localparam logic [6:0] CNT_END      = 7'(2 * ROW_CHARS);
	localparam logic [6:0] CNT_ROW2_END = 7'(64 + ROW_CHARS);

	logic [6:0] count_q, count_d;
	logic       failed_q, failed_d;
	logic       pos_ok;
	logic [7:0] base;
	logic [7:0] addr_cmd;
	logic [6:0] pos_count;
	logic       over;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	assign pos_ok    = (row == 8'd1 || row == 8'd2) && position != 8'd0
		&& position <= POS_MAX;
	assign base      = (row == 8'd2) ? lcdx_pkg::ROW2_BASE : 8'd0;
	assign addr_cmd  = (base + position - 8'd1) | lcdx_pkg::CMD_SET_DDRAM;
	assign pos_count = base[6:0] + position[6:0];
	// counter at or above 0x40 means the string runs on row 2
	assign over      = count_q[6] ? (count_q > CNT_ROW2_END) : (count_q > CNT_ROW);

	always_comb begin
		job      = '0;
		count_d  = count_q;
		failed_d = failed_q;
		unique case (lcdx_pkg::mode_t'(mode))
			lcdx_pkg::MODE_CMD: begin
				job.cmd_en = 1'b1;
				job.cmd    = value;
			end
			lcdx_pkg::MODE_DATA: begin
				job.dat_en = 1'b1;
				job.dat    = value;
			end
			lcdx_pkg::MODE_CHAR: begin
				if (!pos_ok) begin
					job.err = 1'b1;
				end else begin
					job.cmd_en = 1'b1;
					job.cmd    = addr_cmd;
					job.dat_en = 1'b1;
					job.dat    = value;
				end
			end
			lcdx_pkg::MODE_STR_HOME: begin
				if (first) begin
					failed_d   = 1'b0;
					count_d    = 7'd1;
					job.cmd_en = 1'b1;
					job.cmd    = lcdx_pkg::CMD_SET_DDRAM;
					job.dat_en = 1'b1;
					job.dat    = value;
				end else if (failed_q) begin
					job.err = 1'b1;
				end else if (count_q >= CNT_END) begin
					failed_d = 1'b1;
					job.err  = 1'b1;
				end else begin
					count_d    = count_q + 7'd1;
					job.cmd_en = (count_q == CNT_ROW);
					job.cmd    = lcdx_pkg::CMD_LINE2;
					job.dat_en = 1'b1;
					job.dat    = value;
				end
			end
			lcdx_pkg::MODE_STR_POS: begin
				if (first) begin
					if (!pos_ok) begin
						failed_d = 1'b1;
						job.err  = 1'b1;
					end else begin
						failed_d   = 1'b0;
						count_d    = pos_count + 7'd1;
						job.cmd_en = 1'b1;
						job.cmd    = addr_cmd;
						job.dat_en = 1'b1;
						job.dat    = value;
					end
				end else if (failed_q) begin
					job.err = 1'b1;
				end else if (over) begin
					failed_d = 1'b1;
					job.err  = 1'b1;
				end else begin
					count_d    = count_q + 7'd1;
					job.dat_en = 1'b1;
					job.dat    = value;
				end
			end
			lcdx_pkg::MODE_GLYPH: begin
				if (glyph_address[7:6] != 2'b00) begin
					job.err = 1'b1;
				end else begin
					job.cmd_en = (glyph_row == 3'd0);
					job.cmd    = lcdx_pkg::CMD_SET_CGRAM | glyph_address;
					job.dat_en = 1'b1;
					job.dat    = value;
				end
			end
			default: begin
				job.err = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			failed_q <= 1'b0;
		end else if (q_push) begin
			count_q  <= count_d;
			failed_q <= failed_d;
		end
	end

endmodule

>>> rtl/lcdx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdx_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module lcdx_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lcdx_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output lcdx_pkg::job_t rd_job,
	output logic           empty
);

	localparam int PW = (lcdx_pkg::QUEUE_DEPTH > 1) ? $clog2(lcdx_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(lcdx_pkg::QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(lcdx_pkg::QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_IX = PW'(lcdx_pkg::QUEUE_DEPTH - 1);

	lcdx_pkg::job_t entry_q [lcdx_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full   = (count_q == DEPTH_C);
	assign empty  = (count_q == '0);
	assign rd_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IX) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IX) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/lcdx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdx_back
// Serializes the queue head to expander bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module lcdx_back (
	input  logic           clk,
	input  logic           arst_n,
	input  lcdx_pkg::job_t job,
	input  logic           q_empty,
	output logic           q_pop,
	input  logic           backlight,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           out_last,
	output logic           out_error
);

	// idx[2] picks command or data byte, idx[1] the nibble, idx[0] enable low
	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       error_q;
	logic       adv;
	logic       job_last;
	logic       use_cmd;
	logic [7:0] lcd_byte;
	logic [3:0] nibble;
	logic [7:0] exp_byte;

	assign use_cmd  = job.cmd_en && !idx_q[2];
	assign lcd_byte = use_cmd ? job.cmd : job.dat;
	assign nibble   = idx_q[1] ? lcd_byte[3:0] : lcd_byte[7:4];
	assign exp_byte = job.err ? 8'd0 : {nibble, backlight, !idx_q[0], 1'b0, !use_cmd};
	assign job_last = job.err
		|| (idx_q[1:0] == 2'b11 && (idx_q[2] || !(job.cmd_en && job.dat_en)));

	assign adv   = !q_empty && (!valid_q || out_ready);
	assign q_pop = adv && job_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				idx_q   <= job_last ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q  <= exp_byte;
			last_q  <= job_last;
			error_q <= job.err;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_error = error_q;

endmodule

>>> rtl/char_lcd_nibble_expander_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_expander_sequencer
// Turns character LCD operations into 4-bit mode port expander bytes.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one lcd operation per transaction: tuser is the mode,
//  tdata holds the operands. m_axis carries expander bytes; tlast marks the
//  final byte of an operation and tuser flags a rejected operation, which is
//  a single zero byte with tlast set.
//  cfg_valid/cfg_ready/cfg_data write the backlight bit; write it only while
//  the block is idle.
//  Each lcd byte expands to four expander bytes, so an operation yields four
//  or eight bytes (one on error). A taken operation is registered in the job
//  queue and its bytes in the output register, which sends one byte per
//  cycle while the receiver is ready.
//  A two-entry job queue lets the next operation be taken while the current
//  one drains. When the receiver stalls, the output register holds, the
//  queue fills, and s_axis_tready drops once it holds two jobs.
//  Reset clears the string counter, the sticky string error and the queue,
//  and turns the backlight bit on.
// ----------------------------------------------------------------------------
module char_lcd_nibble_expander_sequencer #(
	parameter int ROW_CHARS = lcdx_pkg::ROW_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// value[7:0], row[15:8], position[23:16], first[24], glyph_address[32:25],
	// glyph_row[35:33], zero fill [39:36]
	input  logic [39:0] s_axis_tdata,
	// mode[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// expander_byte[7:0]
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast,
	// error[0]
	output logic        m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	// backlight_on[0]
	input  logic        cfg_data
);

	logic           backlight_q;
	lcdx_pkg::job_t wr_job;
	lcdx_pkg::job_t rd_job;
	logic           q_full, q_empty, q_push, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= 1'b1;
		end else if (cfg_valid) begin
			backlight_q <= cfg_data;
		end
	end

	lcdx_front #(
		.ROW_CHARS(ROW_CHARS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.mode         (s_axis_tuser),
		.value        (s_axis_tdata[7:0]),
		.row          (s_axis_tdata[15:8]),
		.position     (s_axis_tdata[23:16]),
		.first        (s_axis_tdata[24]),
		.glyph_address(s_axis_tdata[32:25]),
		.glyph_row    (s_axis_tdata[35:33]),
		.q_full       (q_full),
		.q_push       (q_push),
		.job          (wr_job)
	);

	lcdx_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wr_job(wr_job),
		.full  (q_full),
		.pop   (q_pop),
		.rd_job(rd_job),
		.empty (q_empty)
	);

	lcdx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (rd_job),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.backlight(backlight_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_byte (m_axis_tdata),
		.out_last (m_axis_tlast),
		.out_error(m_axis_tuser)
	);

	// a rejected operation is one zero byte that closes the operation
	a_error_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0 && m_axis_tlast)
		else $error("error transaction without zero byte and tlast");

	// backlight bit follows the register on every regular byte
	a_backlight: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[3] == backlight_q)
		else $error("backlight bit differs from register");

	// an enable-high strobe is always followed by its enable-low byte
	a_enable_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser && m_axis_tdata[2] |-> !m_axis_tlast)
		else $error("operation ends on an enable-high byte");

	// a push is never taken while the queue is full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("job queue overflow");

endmodule

>>> dv/char_lcd_nibble_expander_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_expander_sequencer_tb
// Self-checking bench for the LCD nibble expander sequencer. Operations go in
// on the slave stream. A local predictor keeps its own string counter,
// sticky string error and backlight bit, and expands every accepted operation
// into the expander bytes it must produce. The master stream is checked byte
// by byte against that expectation. Directed corner cases come first. Random
// phases follow, with alternating backlight settings and varied idling.
// ----------------------------------------------------------------------------
module char_lcd_nibble_expander_sequencer_tb;

	localparam int ROW_CHARS     = lcdx_pkg::ROW_CHARS_DEF;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_PAUSE   = 20;
	localparam int PHASE_OPS     = 65;

	// mode codes the block must reject
	localparam logic [2:0] MODE_RSVD_LO = 3'd6;
	localparam logic [2:0] MODE_RSVD_HI = 3'd7;

	// expander control bits
	localparam logic [7:0] XP_EN = 8'h04;
	localparam logic [7:0] XP_BL = 8'h08;

	typedef enum int {RX_ALWAYS, RX_LIGHT, RX_HEAVY} rx_stall_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] value;
		logic [7:0] row;
		logic [7:0] pos;
		logic       first;
		logic [7:0] gaddr;
		logic [2:0] grow;
	} lcd_op_t;

	typedef struct packed {
		logic [7:0] xbyte;
		logic       last;
		logic       err;
	} xp_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	// predictor state
	logic [6:0] str_count = '0;
	logic       str_failed = 1'b0;
	logic       backlight = 1'b1;

	lcd_op_t   pend_ops[$];
	xp_byte_t  xp_expected[$];
	lcd_op_t   cur_op;
	xp_byte_t  oldest;

	int        queued_ops = 0;
	int        ops_taken = 0;
	int        bytes_checked = 0;
	int        rejects_seen = 0;
	int        mismatch_count = 0;
	int        cycles = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        rdy_idx = 0;
	logic [31:0] rdy_pat = '1;
	logic        idle_en = 1'b0;
	rx_stall_t   stall_mode = RX_ALWAYS;

	char_lcd_nibble_expander_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------
	task automatic push_xp(input logic [7:0] b, input logic is_last, input logic is_err);
		xp_byte_t e;
		e.xbyte = b;
		e.last  = is_last;
		e.err   = is_err;
		xp_expected.push_back(e);
	endtask

	// one lcd byte becomes two enable pulses, upper nibble first
	task automatic push_lcd_byte(input logic [7:0] b, input logic rs);
		logic [7:0] ctl;
		ctl = (backlight ? XP_BL : 8'h00) | {7'd0, rs};
		push_xp({b[7:4], 4'h0} | XP_EN | ctl, 1'b0, 1'b0);
		push_xp({b[7:4], 4'h0} | ctl, 1'b0, 1'b0);
		push_xp({b[3:0], 4'h0} | XP_EN | ctl, 1'b0, 1'b0);
		push_xp({b[3:0], 4'h0} | ctl, 1'b0, 1'b0);
	endtask

	task automatic expand_lcd_op(input lcd_op_t op);
		logic [7:0] base;
		logic       pos_good;
		logic       rejected;
		logic       past_end;
		xp_byte_t   tail;
		pos_good = (op.row == 8'd1 || op.row == 8'd2) && op.pos >= 8'd1 &&
			op.pos <= ROW_CHARS;
		base = (op.row == 8'd2) ? lcdx_pkg::ROW2_BASE : 8'h00;
		rejected = 1'b0;
		case (op.mode)
			lcdx_pkg::MODE_CMD: push_lcd_byte(op.value, 1'b0);
			lcdx_pkg::MODE_DATA: push_lcd_byte(op.value, 1'b1);
			lcdx_pkg::MODE_CHAR: begin
				if (!pos_good) begin
					rejected = 1'b1;
				end else begin
					push_lcd_byte(lcdx_pkg::CMD_SET_DDRAM | (base + op.pos - 8'd1), 1'b0);
					push_lcd_byte(op.value, 1'b1);
				end
			end
			lcdx_pkg::MODE_STR_HOME: begin
				if (op.first) begin
					str_count = '0;
					str_failed = 1'b0;
					push_lcd_byte(lcdx_pkg::CMD_SET_DDRAM, 1'b0);
				end
				if (!op.first && str_failed) begin
					rejected = 1'b1;
				end else if (str_count >= 2 * ROW_CHARS) begin
					str_failed = 1'b1;
					rejected = 1'b1;
				end else begin
					if (str_count == ROW_CHARS)
						push_lcd_byte(lcdx_pkg::CMD_LINE2, 1'b0);
					str_count = str_count + 7'd1;
					push_lcd_byte(op.value, 1'b1);
				end
			end
			lcdx_pkg::MODE_GLYPH: begin
				if (op.gaddr > 8'h3F) begin
					rejected = 1'b1;
				end else begin
					if (op.grow == 3'd0)
						push_lcd_byte(lcdx_pkg::CMD_SET_CGRAM | op.gaddr, 1'b0);
					push_lcd_byte(op.value, 1'b1);
				end
			end
			lcdx_pkg::MODE_STR_POS: begin
				if (op.first) begin
					str_failed = 1'b0;
					if (!pos_good) begin
						str_failed = 1'b1;
						rejected = 1'b1;
					end else begin
						push_lcd_byte(lcdx_pkg::CMD_SET_DDRAM | (base + op.pos - 8'd1),
							1'b0);
						str_count = 7'(base + op.pos);
					end
				end else if (str_failed) begin
					rejected = 1'b1;
				end
				if (!rejected) begin
					// counter at or above the row 2 base means the string is on row 2
					if (str_count >= lcdx_pkg::ROW2_BASE)
						past_end = str_count > lcdx_pkg::ROW2_BASE + ROW_CHARS;
					else
						past_end = str_count > ROW_CHARS;
					if (past_end) begin
						str_failed = 1'b1;
						rejected = 1'b1;
					end else begin
						str_count = str_count + 7'd1;
						push_lcd_byte(op.value, 1'b1);
					end
				end
			end
			default: rejected = 1'b1;
		endcase
		if (rejected) begin
			push_xp(8'h00, 1'b1, 1'b1);
		end else begin
			tail = xp_expected.pop_back();
			tail.last = 1'b1;
			xp_expected.push_back(tail);
		end
	endtask

	// ------------------------------------------------------------------------
	// driver: bursts of operations separated by random gaps
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expand_lcd_op(cur_op);
				ops_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0 || pend_ops.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_axis_tvalid <= 1'b0;
				end else begin
					cur_op = pend_ops.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= cur_op.mode;
					s_axis_tdata <= {4'h0, cur_op.grow, cur_op.gaddr, cur_op.first,
						cur_op.pos, cur_op.row, cur_op.value};
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						if (!idle_en)
							gap_left = 0;
						else if ($urandom_range(0, 7) == 0)
							gap_left = $urandom_range(10, 30);
						else
							gap_left = $urandom_range(0, 4);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: checks each byte transaction, then picks the next ready value
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				bytes_checked++;
				if (m_axis_tuser === 1'b1)
					rejects_seen++;
				if (xp_expected.size() == 0) begin
					mismatch_count++;
					$display({"%0t: unexpected byte, expected none, ",
						"actual byte=%02h last=%0d err=%0d"},
						$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
				end else begin
					oldest = xp_expected.pop_front();
					if (m_axis_tdata !== oldest.xbyte || m_axis_tlast !== oldest.last ||
							m_axis_tuser !== oldest.err) begin
						mismatch_count++;
						$display({"%0t: expected byte=%02h last=%0d err=%0d, ",
							"actual byte=%02h last=%0d err=%0d"},
							$time, oldest.xbyte, oldest.last, oldest.err,
							m_axis_tdata, m_axis_tlast, m_axis_tuser);
					end
				end
			end
			rdy_idx = rdy_idx + 1;
			if (rdy_idx == 16) begin
				rdy_idx = 0;
				rdy_pat = $urandom;
			end
			case (stall_mode)
				RX_ALWAYS: m_axis_tready <= 1'b1;
				RX_LIGHT:  m_axis_tready <= rdy_pat[rdy_idx] | rdy_pat[rdy_idx + 16];
				default:   m_axis_tready <= rdy_pat[rdy_idx] & rdy_pat[rdy_idx + 16];
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic add_op(input logic [2:0] mode, input logic [7:0] value,
			input logic [7:0] row, input logic [7:0] pos, input logic first,
			input logic [7:0] gaddr, input logic [2:0] grow);
		lcd_op_t op;
		op.mode  = mode;
		op.value = value;
		op.row   = row;
		op.pos   = pos;
		op.first = first;
		op.gaddr = gaddr;
		op.grow  = grow;
		pend_ops.push_back(op);
		queued_ops++;
	endtask

	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [2:0] rnd3();
		return 3'($urandom_range(0, 7));
	endfunction

	// mostly well-formed strings and glyphs, some continuations and noise
	task automatic add_random_group();
		int kind;
		int len;
		int i;
		logic [7:0] row;
		logic [7:0] pos;
		logic [7:0] gaddr;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1: begin
				if ($urandom_range(0, 2) == 0)
					len = $urandom_range(30, 36);
				else
					len = $urandom_range(1, 20);
				for (i = 0; i < len; i++)
					add_op(lcdx_pkg::MODE_STR_HOME, rnd8(), rnd8(), rnd8(), i == 0, rnd8(),
						rnd3());
			end
			2, 3: begin
				if ($urandom_range(0, 5) == 0) begin
					row = rnd8();
					pos = rnd8();
					len = $urandom_range(1, 3);
				end else begin
					row = 8'($urandom_range(1, 2));
					pos = 8'($urandom_range(1, ROW_CHARS));
					len = $urandom_range(1, ROW_CHARS - pos + 3);
				end
				for (i = 0; i < len; i++)
					add_op(lcdx_pkg::MODE_STR_POS, rnd8(), row, pos, i == 0, rnd8(), rnd3());
			end
			4: begin
				if ($urandom_range(0, 5) == 0)
					gaddr = rnd8();
				else
					gaddr = {2'b00, 3'($urandom_range(0, 7)), 3'b000};
				for (i = 0; i < 8; i++)
					add_op(lcdx_pkg::MODE_GLYPH, rnd8(), rnd8(), rnd8(), rnd8() > 8'd127,
						gaddr, 3'(i));
			end
			5: begin
				if ($urandom_range(0, 3) == 0)
					add_op(lcdx_pkg::MODE_CHAR, rnd8(), rnd8(), rnd8(), 1'b0, rnd8(), rnd3());
				else
					add_op(lcdx_pkg::MODE_CHAR, rnd8(), 8'($urandom_range(1, 2)),
						8'($urandom_range(1, ROW_CHARS)), 1'b0, rnd8(), rnd3());
			end
			6: add_op(3'($urandom_range(0, 1)), rnd8(), rnd8(), rnd8(), rnd8() > 8'd127,
				rnd8(), rnd3());
			7: begin
				// string characters without a start, on whatever counter is left
				len = $urandom_range(1, 4);
				for (i = 0; i < len; i++)
					add_op($urandom_range(0, 1) ? lcdx_pkg::MODE_STR_POS :
						lcdx_pkg::MODE_STR_HOME, rnd8(), rnd8(), rnd8(), 1'b0, rnd8(), rnd3());
			end
			default: add_op(rnd3(), rnd8(), rnd8(), rnd8(), rnd8() > 8'd127, rnd8(), rnd3());
		endcase
	endtask

	task automatic wait_drained();
		while (pend_ops.size() != 0 || s_axis_tvalid || xp_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic write_backlight(input logic bl);
		cfg_valid <= 1'b1;
		cfg_data <= bl;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		backlight = bl;
	endtask

	initial begin
		int ph;
		int target;

		// string character with no start right after reset
		add_op(lcdx_pkg::MODE_STR_HOME, 8'h41, 8'h00, 8'h00, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_CMD,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_CMD,  8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 3'd7);
		add_op(lcdx_pkg::MODE_DATA, 8'hA5, 8'h00, 8'h00, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_DATA, 8'h5A, 8'h00, 8'h00, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_CHAR, 8'h30, 8'd1, 8'd1, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_CHAR, 8'h31, 8'd2, 8'd16, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_CHAR, 8'h32, 8'd0, 8'd5, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_CHAR, 8'h33, 8'd3, 8'd1, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_CHAR, 8'h34, 8'd1, 8'd0, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_CHAR, 8'h35, 8'd2, 8'd17, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_CHAR, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_GLYPH, 8'h1F, 8'h00, 8'h00, 1'b0, 8'd0, 3'd0);
		add_op(lcdx_pkg::MODE_GLYPH, 8'hFF, 8'h00, 8'h00, 1'b0, 8'd63, 3'd7);
		add_op(lcdx_pkg::MODE_GLYPH, 8'h11, 8'h00, 8'h00, 1'b0, 8'd64, 3'd0);
		add_op(lcdx_pkg::MODE_GLYPH, 8'h0E, 8'h00, 8'h00, 1'b0, 8'd255, 3'd3);
		add_op(MODE_RSVD_LO, 8'h12, 8'd1, 8'd1, 1'b1, 8'h00, 3'd0);
		add_op(MODE_RSVD_HI, 8'h34, 8'd1, 8'd1, 1'b1, 8'h00, 3'd0);
		// row 2 string starting at its last column runs off the end, then stays failed
		add_op(lcdx_pkg::MODE_STR_POS, 8'h41, 8'd2, 8'd16, 1'b1, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_STR_POS, 8'h42, 8'd0, 8'd0, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_STR_POS, 8'h43, 8'd0, 8'd0, 1'b0, 8'h00, 3'd0);
		// bad start position, sticky error shared with the home string
		add_op(lcdx_pkg::MODE_STR_POS, 8'h44, 8'd0, 8'd1, 1'b1, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_STR_HOME, 8'h45, 8'd0, 8'd0, 1'b0, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_STR_HOME, 8'h46, 8'd0, 8'd0, 1'b1, 8'h00, 3'd0);
		// row 1 end of row
		add_op(lcdx_pkg::MODE_STR_POS, 8'h47, 8'd1, 8'd16, 1'b1, 8'h00, 3'd0);
		add_op(lcdx_pkg::MODE_STR_POS, 8'h48, 8'd1, 8'd16, 1'b0, 8'h00, 3'd0);

		idle_en = 1'b1;
		stall_mode = RX_LIGHT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			write_backlight(ph[0]);
			case (ph)
				0: begin idle_en = 1'b1; stall_mode = RX_LIGHT;  end
				1: begin idle_en = 1'b0; stall_mode = RX_ALWAYS; end
				2: begin idle_en = 1'b1; stall_mode = RX_HEAVY;  end
				default: begin idle_en = 1'b1; stall_mode = RX_LIGHT; end
			endcase
			target = queued_ops + PHASE_OPS;
			while (queued_ops < target)
				add_random_group();
			// sender holds off until everything of this phase is back
			wait_drained();
		end

		if (xp_expected.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d expected bytes never arrived", $time, xp_expected.size());
		end
		$display("run covered %0d lcd operations over all modes and unused codes, %0d rejected",
			ops_taken, rejects_seen);
		$display("checked %0d expander bytes with backlight off and on, gaps and stalls",
			bytes_checked);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
